// ----- rtl/eims_pkg.sv -----
package eims_pkg;

    localparam int MAP_WIDTH  = 256;
    localparam int MAP_HEIGHT = 128;
    localparam int W_BITS     = $clog2(MAP_WIDTH);
    localparam int H_BITS     = $clog2(MAP_HEIGHT);
    localparam int CELL_BITS  = W_BITS + H_BITS;
    localparam int SRCH_BITS  = ((W_BITS > H_BITS) ? W_BITS : H_BITS) + 1;

    localparam int CH_BITS    = 16;
    localparam int LUMA_BITS  = 17;
    localparam int SINE_BITS  = 9;
    localparam int WL_BITS    = 24;
    localparam int CDF_BITS   = 25;
    localparam int KEY_BITS   = 24;
    localparam int RSUM_BITS  = W_BITS + WL_BITS;
    localparam int RINT_BITS  = 32;
    localparam int SINT_BITS  = RINT_BITS + H_BITS;
    localparam int FRAC_SHIFT = 24;
    localparam int NUM_BITS   = 64;
    localparam int DEN_BITS   = 40;
    localparam int DCNT_BITS  = $clog2(NUM_BITS);

    localparam int COL_BITS   = 8;
    localparam int ROW_BITS   = 7;
    localparam int DENS_BITS  = 32;
    localparam int STAT_BITS  = 2;

    localparam logic [CH_BITS-1:0]  LUMA_R    = 16'd13933;
    localparam logic [CH_BITS-1:0]  LUMA_G    = 16'd46871;
    localparam logic [CH_BITS-1:0]  LUMA_B    = 16'd4732;
    localparam logic [33:0]         LUMA_RND  = 34'd32768;
    localparam logic [CDF_BITS-1:0] CDF_ONE   = 25'h1000000;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [STAT_BITS-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_BUILT = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_LD_MUL, ST_LD_SUM, ST_LD_WR,
        ST_ROW_INIT, ST_SUM_RD, ST_SUM_ACC,
        ST_CDF_INIT, ST_CDF_RD, ST_CDF_ACC, ST_CDF_START, ST_CDF_DIV, ST_CDF_WR,
        ST_ROW_END,
        ST_MRG_INIT, ST_MRG_RD, ST_MRG_ACC, ST_MRG_START, ST_MRG_DIV, ST_MRG_WR,
        ST_BUILD_DONE,
        ST_Q_START, ST_SRCH_CHK, ST_SRCH_RD, ST_SRCH_CMP,
        ST_DENS_RD, ST_DENS_CHK, ST_DENS_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_capture;
        logic query_capture;
        logic ld_write;
        logic row_init;
        logic sum_acc;
        logic cdf_init;
        logic prefix_acc;
        logic div_start_cdf;
        logic cdf_write;
        logic row_end;
        logic mrg_init;
        logic mrg_acc;
        logic div_start_mrg;
        logic mrg_write;
        logic build_done;
        logic stage_empty;
        logic srch_init_mrg;
        logic srch_init_row;
        logic srch_mid;
        logic srch_cmp;
        logic srch_finish;
        logic dens_sel;
        logic dens_zero;
        logic div_start_dens;
        logic dens_write;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic last_pixel;
        logic x_last;
        logic y_last;
        logic rowsum_zero;
        logic sumint_zero;
        logic div_done;
        logic div_busy;
        logic query_ok;
        logic srch_done;
        logic srch_row;
        logic rowint_zero;
        logic out_free;
    } stat_t;

    typedef logic [SINE_BITS-1:0] sine_table_t [MAP_HEIGHT];

    function automatic sine_table_t build_sine_table();
        sine_table_t       tbl;
        longint unsigned   a;
        longint unsigned   b;
        longint unsigned   p;
        longint unsigned   d;
        longint unsigned   n;
        longint unsigned   q;
        for (int y = 0; y < MAP_HEIGHT; y++) begin
            a = 2 * longint'(y) + 1;
            b = 2 * longint'(MAP_HEIGHT);
            p = a * (b - a);
            d = 5 * b * b - 4 * p;
            n = 4096 * p + (d >> 1);
            q = 0;
            for (int i = SINE_BITS - 1; i >= 0; i--) begin
                if (n >= (d << i)) begin
                    n = n - (d << i);
                    q = q + (64'd1 << i);
                end
            end
            tbl[y] = SINE_BITS'(q);
        end
        return tbl;
    endfunction

    localparam sine_table_t ROW_SINE = build_sine_table();

endpackage

// ----- rtl/eims_div.sv -----
module eims_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [eims_pkg::NUM_BITS-1:0]  num,
    input  logic [eims_pkg::DEN_BITS-1:0]  den,
    output logic                           busy,
    output logic                           done,
    output logic [eims_pkg::NUM_BITS-1:0]  quot
);

    logic [eims_pkg::DEN_BITS-1:0]  rem_reg, rem_next;
    logic [eims_pkg::NUM_BITS-1:0]  quo_reg, quo_next;
    logic [eims_pkg::DEN_BITS-1:0]  den_reg, den_next;
    logic [eims_pkg::DCNT_BITS-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [eims_pkg::DEN_BITS:0]    shifted;
    logic [eims_pkg::DEN_BITS:0]    diff;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[eims_pkg::NUM_BITS-1]};
        diff      = shifted - {1'b0, den_reg};
        if (start) begin
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
            cnt_next  = eims_pkg::DCNT_BITS'(eims_pkg::NUM_BITS - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, den_reg}) begin
                rem_next = diff[eims_pkg::DEN_BITS-1:0];
                quo_next = {quo_reg[eims_pkg::NUM_BITS-2:0], 1'b1};
            end else begin
                rem_next = shifted[eims_pkg::DEN_BITS-1:0];
                quo_next = {quo_reg[eims_pkg::NUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quo_reg;

endmodule

// ----- rtl/eims_dp.sv -----
module eims_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  eims_pkg::cmd_t                  cmd,
    output eims_pkg::stat_t                 stat,
    input  logic [eims_pkg::CH_BITS-1:0]    s_red,
    input  logic [eims_pkg::CH_BITS-1:0]    s_green,
    input  logic [eims_pkg::CH_BITS-1:0]    s_blue,
    input  logic                            s_last_pixel,
    input  logic [eims_pkg::CH_BITS-1:0]    s_u_query,
    input  logic [eims_pkg::CH_BITS-1:0]    s_v_query,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [eims_pkg::COL_BITS-1:0]   m_column_index,
    output logic [eims_pkg::ROW_BITS-1:0]   m_row_index,
    output logic [eims_pkg::DENS_BITS-1:0]  m_density,
    output logic [eims_pkg::STAT_BITS-1:0]  m_status
);

    localparam int CELLS = eims_pkg::MAP_WIDTH * eims_pkg::MAP_HEIGHT;

    logic [eims_pkg::CH_BITS-1:0]   r_reg, g_reg, b_reg, u_reg, v_reg;
    logic                           last_reg;
    logic [31:0]                    prod_r_reg, prod_g_reg, prod_b_reg;
    logic [eims_pkg::LUMA_BITS-1:0] luma_reg;
    logic [33:0]                    luma_sum;
    logic [25:0]                    wl_full;
    logic [eims_pkg::WL_BITS-1:0]   wl_val;

    logic [eims_pkg::CELL_BITS:0]   pos_reg;
    logic                           built_reg;
    logic [eims_pkg::W_BITS-1:0]    x_reg;
    logic [eims_pkg::H_BITS-1:0]    y_reg;
    logic [eims_pkg::RSUM_BITS-1:0] rowsum_reg;
    logic [eims_pkg::SINT_BITS-1:0] prefix_reg;
    logic [eims_pkg::SINT_BITS-1:0] sumint_reg;
    logic [eims_pkg::RINT_BITS-1:0] total_reg;
    logic [eims_pkg::RSUM_BITS+7:0] rint_scaled;
    logic [eims_pkg::RINT_BITS-1:0] rint_val;

    logic [eims_pkg::WL_BITS-1:0]   luma_mem [CELLS];
    logic [eims_pkg::CDF_BITS-1:0]  cdf_mem  [CELLS];
    logic [eims_pkg::RINT_BITS-1:0] rint_mem [eims_pkg::MAP_HEIGHT];
    logic [eims_pkg::CDF_BITS-1:0]  mrg_mem  [eims_pkg::MAP_HEIGHT];
    logic [eims_pkg::WL_BITS-1:0]   luma_rd_reg;
    logic [eims_pkg::CDF_BITS-1:0]  cdf_rd_reg, mrg_rd_reg;
    logic [eims_pkg::RINT_BITS-1:0] rint_rd_reg;
    logic [eims_pkg::CELL_BITS-1:0] luma_ra;
    logic [eims_pkg::H_BITS-1:0]    rint_ra;
    logic [eims_pkg::H_BITS-1:0]    dv;
    logic [eims_pkg::W_BITS-1:0]    du;
    logic [eims_pkg::CDF_BITS-1:0]  cdf_wd, mrg_wd;

    logic                           sel_reg;
    logic [eims_pkg::SRCH_BITS-1:0] lo_reg, hi_reg, mid_reg, mid_m1;
    logic [eims_pkg::SRCH_BITS:0]   mid_sum;
    logic [eims_pkg::H_BITS-1:0]    vi_reg;
    logic [eims_pkg::CDF_BITS-1:0]  srch_val;
    logic [eims_pkg::KEY_BITS-1:0]  srch_key;

    logic [eims_pkg::COL_BITS-1:0]  res_col_reg;
    logic [eims_pkg::ROW_BITS-1:0]  res_row_reg;
    logic [eims_pkg::DENS_BITS-1:0] res_dens_reg;
    eims_pkg::status_t              res_status_reg;
    logic                           m_valid_reg;
    logic [eims_pkg::COL_BITS-1:0]  m_col_reg;
    logic [eims_pkg::ROW_BITS-1:0]  m_row_reg;
    logic [eims_pkg::DENS_BITS-1:0] m_dens_reg;
    logic [eims_pkg::STAT_BITS-1:0] m_status_reg;

    logic                           div_start, div_busy, div_done;
    logic [eims_pkg::NUM_BITS-1:0]  div_num, div_quot;
    logic [eims_pkg::DEN_BITS-1:0]  div_den;

    function automatic logic [eims_pkg::SRCH_BITS-1:0] pick_index(
        input logic [eims_pkg::SRCH_BITS-1:0] idx,
        input logic [eims_pkg::SRCH_BITS-1:0] lim
    );
        logic [eims_pkg::SRCH_BITS-1:0] res;
        if (idx == '0) begin
            res = '0;
        end else if (idx - 1'b1 > lim - 1'b1) begin
            res = lim - 1'b1;
        end else begin
            res = idx - 1'b1;
        end
        return res;
    endfunction

    always_comb begin
        luma_sum = {2'b00, prod_r_reg} + {2'b00, prod_g_reg} + {2'b00, prod_b_reg}
                   + eims_pkg::LUMA_RND;
        wl_full = luma_reg * eims_pkg::ROW_SINE[pos_reg[eims_pkg::CELL_BITS-1:eims_pkg::W_BITS]];
        wl_val = wl_full[eims_pkg::WL_BITS-1:0];
        rint_scaled = {rowsum_reg, 8'd0} >> eims_pkg::W_BITS;
        rint_val = rint_scaled[eims_pkg::RINT_BITS-1:0];
        dv = v_reg[eims_pkg::CH_BITS-1 -: eims_pkg::H_BITS];
        du = u_reg[eims_pkg::CH_BITS-1 -: eims_pkg::W_BITS];
        luma_ra = cmd.dens_sel ? {dv, du} : {y_reg, x_reg};
        rint_ra = cmd.dens_sel ? dv : y_reg;
        cdf_wd = (rowsum_reg == '0) ? ((&x_reg) ? eims_pkg::CDF_ONE : '0)
                                    : div_quot[eims_pkg::CDF_BITS-1:0];
        mrg_wd = (sumint_reg == '0) ? ((&y_reg) ? eims_pkg::CDF_ONE : '0)
                                    : div_quot[eims_pkg::CDF_BITS-1:0];
        mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
        mid_m1 = mid_reg - 1'b1;
        srch_key = sel_reg ? {u_reg, 8'd0} : {v_reg, 8'd0};
        srch_val = (mid_reg == '0) ? '0 : (sel_reg ? cdf_rd_reg : mrg_rd_reg);
        div_start = cmd.div_start_cdf | cmd.div_start_mrg | cmd.div_start_dens;
        if (cmd.div_start_dens) begin
            div_num = eims_pkg::NUM_BITS'({luma_rd_reg, 24'd0});
            div_den = eims_pkg::DEN_BITS'(total_reg);
        end else if (cmd.div_start_mrg) begin
            div_num = eims_pkg::NUM_BITS'({prefix_reg, 24'd0});
            div_den = eims_pkg::DEN_BITS'(sumint_reg);
        end else begin
            div_num = eims_pkg::NUM_BITS'({prefix_reg, 24'd0});
            div_den = eims_pkg::DEN_BITS'(rowsum_reg);
        end
    end

    eims_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (cmd.ld_write && !pos_reg[eims_pkg::CELL_BITS]) begin
            luma_mem[pos_reg[eims_pkg::CELL_BITS-1:0]] <= wl_val;
        end
        luma_rd_reg <= luma_mem[luma_ra];
    end

    always_ff @(posedge aclk) begin
        if (cmd.cdf_write) begin
            cdf_mem[{y_reg, x_reg}] <= cdf_wd;
        end
        cdf_rd_reg <= cdf_mem[{vi_reg, mid_m1[eims_pkg::W_BITS-1:0]}];
    end

    always_ff @(posedge aclk) begin
        if (cmd.row_end) begin
            rint_mem[y_reg] <= rint_val;
        end
        rint_rd_reg <= rint_mem[rint_ra];
    end

    always_ff @(posedge aclk) begin
        if (cmd.mrg_write) begin
            mrg_mem[y_reg] <= mrg_wd;
        end
        mrg_rd_reg <= mrg_mem[mid_m1[eims_pkg::H_BITS-1:0]];
    end

    always_ff @(posedge aclk) begin
        prod_r_reg <= r_reg * eims_pkg::LUMA_R;
        prod_g_reg <= g_reg * eims_pkg::LUMA_G;
        prod_b_reg <= b_reg * eims_pkg::LUMA_B;
        luma_reg   <= luma_sum[32:16];
        if (cmd.load_capture) begin
            r_reg    <= s_red;
            g_reg    <= s_green;
            b_reg    <= s_blue;
            last_reg <= s_last_pixel;
        end
        if (cmd.query_capture) begin
            u_reg <= s_u_query;
            v_reg <= s_v_query;
        end
        if (cmd.ld_write && last_reg) begin
            y_reg      <= '0;
            sumint_reg <= '0;
        end
        if (cmd.row_init) begin
            x_reg      <= '0;
            rowsum_reg <= '0;
        end
        if (cmd.sum_acc) begin
            rowsum_reg <= rowsum_reg + eims_pkg::RSUM_BITS'(luma_rd_reg);
            x_reg      <= x_reg + 1'b1;
        end
        if (cmd.cdf_init) begin
            x_reg      <= '0;
            prefix_reg <= '0;
        end
        if (cmd.prefix_acc) begin
            prefix_reg <= prefix_reg + eims_pkg::SINT_BITS'(luma_rd_reg);
        end
        if (cmd.cdf_write) begin
            x_reg <= x_reg + 1'b1;
        end
        if (cmd.row_end) begin
            sumint_reg <= sumint_reg + eims_pkg::SINT_BITS'(rint_val);
            y_reg      <= y_reg + 1'b1;
        end
        if (cmd.mrg_init) begin
            y_reg      <= '0;
            prefix_reg <= '0;
        end
        if (cmd.mrg_acc) begin
            prefix_reg <= prefix_reg + eims_pkg::SINT_BITS'(rint_rd_reg);
        end
        if (cmd.mrg_write) begin
            y_reg <= y_reg + 1'b1;
        end
        if (cmd.srch_init_mrg) begin
            sel_reg <= 1'b0;
            lo_reg  <= '0;
            hi_reg  <= eims_pkg::SRCH_BITS'(eims_pkg::MAP_HEIGHT + 1);
        end
        if (cmd.srch_init_row) begin
            sel_reg     <= 1'b1;
            lo_reg      <= '0;
            hi_reg      <= eims_pkg::SRCH_BITS'(eims_pkg::MAP_WIDTH + 1);
            vi_reg      <= eims_pkg::H_BITS'(pick_index(lo_reg,
                               eims_pkg::SRCH_BITS'(eims_pkg::MAP_HEIGHT)));
            res_row_reg <= eims_pkg::ROW_BITS'(pick_index(lo_reg,
                               eims_pkg::SRCH_BITS'(eims_pkg::MAP_HEIGHT)));
        end
        if (cmd.srch_mid) begin
            mid_reg <= mid_sum[eims_pkg::SRCH_BITS:1];
        end
        if (cmd.srch_cmp) begin
            if (srch_val < {1'b0, srch_key}) begin
                lo_reg <= mid_reg + 1'b1;
            end else begin
                hi_reg <= mid_reg;
            end
        end
        if (cmd.srch_finish) begin
            res_col_reg <= eims_pkg::COL_BITS'(pick_index(lo_reg,
                               eims_pkg::SRCH_BITS'(eims_pkg::MAP_WIDTH)));
        end
        if (cmd.dens_zero) begin
            res_dens_reg   <= '0;
            res_status_reg <= eims_pkg::STATUS_OK;
        end
        if (cmd.dens_write) begin
            res_dens_reg   <= (|div_quot[eims_pkg::NUM_BITS-1:eims_pkg::DENS_BITS]) ? '1
                              : div_quot[eims_pkg::DENS_BITS-1:0];
            res_status_reg <= eims_pkg::STATUS_OK;
        end
        if (cmd.stage_empty) begin
            res_col_reg    <= '0;
            res_row_reg    <= '0;
            res_dens_reg   <= '0;
            res_status_reg <= eims_pkg::STATUS_EMPTY;
        end
        if (cmd.build_done) begin
            res_col_reg    <= '0;
            res_row_reg    <= '0;
            res_dens_reg   <= '0;
            res_status_reg <= (total_reg != '0) ? eims_pkg::STATUS_BUILT
                                                : eims_pkg::STATUS_EMPTY;
        end
        if (cmd.out_load) begin
            m_col_reg    <= res_col_reg;
            m_row_reg    <= res_row_reg;
            m_dens_reg   <= res_dens_reg;
            m_status_reg <= res_status_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            built_reg   <= 1'b0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.load_capture) begin
                built_reg <= 1'b0;
            end
            if (cmd.ld_write && !pos_reg[eims_pkg::CELL_BITS]) begin
                pos_reg <= pos_reg + 1'b1;
            end
            if (cmd.mrg_init) begin
                total_reg <= sumint_reg[eims_pkg::SINT_BITS-1:eims_pkg::H_BITS];
            end
            if (cmd.build_done) begin
                pos_reg   <= '0;
                built_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        stat.last_pixel  = last_reg;
        stat.x_last      = &x_reg;
        stat.y_last      = &y_reg;
        stat.rowsum_zero = (rowsum_reg == '0);
        stat.sumint_zero = (sumint_reg == '0);
        stat.div_done    = div_done;
        stat.div_busy    = div_busy;
        stat.query_ok    = built_reg && (total_reg != '0);
        stat.srch_done   = !(lo_reg < hi_reg);
        stat.srch_row    = sel_reg;
        stat.rowint_zero = (rint_rd_reg == '0);
        stat.out_free    = !m_valid_reg || m_ready;
    end

    assign m_valid        = m_valid_reg;
    assign m_column_index = m_col_reg;
    assign m_row_index    = m_row_reg;
    assign m_density      = m_dens_reg;
    assign m_status       = m_status_reg;

endmodule

// ----- rtl/eims_ctrl.sv -----
module eims_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_req_type,
    output logic             s_ready,
    input  eims_pkg::stat_t  stat,
    output eims_pkg::cmd_t   cmd
);

    eims_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= eims_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            eims_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_req_type == eims_pkg::REQ_LOAD) ? eims_pkg::ST_LD_MUL
                                                                    : eims_pkg::ST_Q_START;
                end
            end
            eims_pkg::ST_LD_MUL:    state_next = eims_pkg::ST_LD_SUM;
            eims_pkg::ST_LD_SUM:    state_next = eims_pkg::ST_LD_WR;
            eims_pkg::ST_LD_WR: begin
                state_next = stat.last_pixel ? eims_pkg::ST_ROW_INIT : eims_pkg::ST_IDLE;
            end
            eims_pkg::ST_ROW_INIT:  state_next = eims_pkg::ST_SUM_RD;
            eims_pkg::ST_SUM_RD:    state_next = eims_pkg::ST_SUM_ACC;
            eims_pkg::ST_SUM_ACC: begin
                state_next = stat.x_last ? eims_pkg::ST_CDF_INIT : eims_pkg::ST_SUM_RD;
            end
            eims_pkg::ST_CDF_INIT:  state_next = eims_pkg::ST_CDF_RD;
            eims_pkg::ST_CDF_RD:    state_next = eims_pkg::ST_CDF_ACC;
            eims_pkg::ST_CDF_ACC: begin
                state_next = stat.rowsum_zero ? eims_pkg::ST_CDF_WR : eims_pkg::ST_CDF_START;
            end
            eims_pkg::ST_CDF_START: state_next = eims_pkg::ST_CDF_DIV;
            eims_pkg::ST_CDF_DIV: begin
                if (stat.div_done) begin
                    state_next = eims_pkg::ST_CDF_WR;
                end
            end
            eims_pkg::ST_CDF_WR: begin
                state_next = stat.x_last ? eims_pkg::ST_ROW_END : eims_pkg::ST_CDF_RD;
            end
            eims_pkg::ST_ROW_END: begin
                state_next = stat.y_last ? eims_pkg::ST_MRG_INIT : eims_pkg::ST_ROW_INIT;
            end
            eims_pkg::ST_MRG_INIT:  state_next = eims_pkg::ST_MRG_RD;
            eims_pkg::ST_MRG_RD:    state_next = eims_pkg::ST_MRG_ACC;
            eims_pkg::ST_MRG_ACC: begin
                state_next = stat.sumint_zero ? eims_pkg::ST_MRG_WR : eims_pkg::ST_MRG_START;
            end
            eims_pkg::ST_MRG_START: state_next = eims_pkg::ST_MRG_DIV;
            eims_pkg::ST_MRG_DIV: begin
                if (stat.div_done) begin
                    state_next = eims_pkg::ST_MRG_WR;
                end
            end
            eims_pkg::ST_MRG_WR: begin
                state_next = stat.y_last ? eims_pkg::ST_BUILD_DONE : eims_pkg::ST_MRG_RD;
            end
            eims_pkg::ST_BUILD_DONE: state_next = eims_pkg::ST_EMIT;
            eims_pkg::ST_Q_START: begin
                state_next = stat.query_ok ? eims_pkg::ST_SRCH_CHK : eims_pkg::ST_EMIT;
            end
            eims_pkg::ST_SRCH_CHK: begin
                if (!stat.srch_done) begin
                    state_next = eims_pkg::ST_SRCH_RD;
                end else if (stat.srch_row) begin
                    state_next = eims_pkg::ST_DENS_RD;
                end
            end
            eims_pkg::ST_SRCH_RD:   state_next = eims_pkg::ST_SRCH_CMP;
            eims_pkg::ST_SRCH_CMP:  state_next = eims_pkg::ST_SRCH_CHK;
            eims_pkg::ST_DENS_RD:   state_next = eims_pkg::ST_DENS_CHK;
            eims_pkg::ST_DENS_CHK: begin
                state_next = stat.rowint_zero ? eims_pkg::ST_EMIT : eims_pkg::ST_DENS_DIV;
            end
            eims_pkg::ST_DENS_DIV: begin
                if (stat.div_done) begin
                    state_next = eims_pkg::ST_EMIT;
                end
            end
            eims_pkg::ST_EMIT: begin
                if (stat.out_free) begin
                    state_next = eims_pkg::ST_IDLE;
                end
            end
            default: state_next = eims_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            eims_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                cmd.load_capture  = s_valid && (s_req_type == eims_pkg::REQ_LOAD);
                cmd.query_capture = s_valid && (s_req_type == eims_pkg::REQ_QUERY);
            end
            eims_pkg::ST_LD_WR:      cmd.ld_write = 1'b1;
            eims_pkg::ST_ROW_INIT:   cmd.row_init = 1'b1;
            eims_pkg::ST_SUM_ACC:    cmd.sum_acc = 1'b1;
            eims_pkg::ST_CDF_INIT:   cmd.cdf_init = 1'b1;
            eims_pkg::ST_CDF_ACC:    cmd.prefix_acc = 1'b1;
            eims_pkg::ST_CDF_START:  cmd.div_start_cdf = 1'b1;
            eims_pkg::ST_CDF_WR:     cmd.cdf_write = 1'b1;
            eims_pkg::ST_ROW_END:    cmd.row_end = 1'b1;
            eims_pkg::ST_MRG_INIT:   cmd.mrg_init = 1'b1;
            eims_pkg::ST_MRG_ACC:    cmd.mrg_acc = 1'b1;
            eims_pkg::ST_MRG_START:  cmd.div_start_mrg = 1'b1;
            eims_pkg::ST_MRG_WR:     cmd.mrg_write = 1'b1;
            eims_pkg::ST_BUILD_DONE: cmd.build_done = 1'b1;
            eims_pkg::ST_Q_START: begin
                cmd.srch_init_mrg = stat.query_ok;
                cmd.stage_empty   = !stat.query_ok;
            end
            eims_pkg::ST_SRCH_CHK: begin
                cmd.srch_mid      = !stat.srch_done;
                cmd.srch_init_row = stat.srch_done && !stat.srch_row;
                cmd.srch_finish   = stat.srch_done && stat.srch_row;
            end
            eims_pkg::ST_SRCH_CMP:   cmd.srch_cmp = 1'b1;
            eims_pkg::ST_DENS_RD:    cmd.dens_sel = 1'b1;
            eims_pkg::ST_DENS_CHK: begin
                cmd.dens_zero      = stat.rowint_zero;
                cmd.div_start_dens = !stat.rowint_zero;
            end
            eims_pkg::ST_DENS_DIV:   cmd.dens_write = stat.div_done;
            eims_pkg::ST_EMIT:       cmd.out_load = stat.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

// ----- rtl/env_map_importance_sampler_core.sv -----
// Importance sampler for a 256 x 128 environment map, one item at a time. A pixel load
// registers the pixel, multiplies, sums and writes its weighted luma. The last pixel starts
// the build, which runs through the map once to sum each row and once more to form the row
// CDF, one 64-step restoring division per entry on the shared divider unless the row sums
// to zero, then once over the rows for the marginal CDF, before the status transfer. A
// query costs two binary searches, each probe a check, a read and a compare (7 or 8 probes
// on the marginal CDF and 8 or 9 on the row CDF), plus one division for the density,
// skipped when the row integral at the scaled cell is zero. The result register lets the
// next item be taken while a result transfer is still pending.
module env_map_importance_sampler_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_req_type,
    input  logic [eims_pkg::CH_BITS-1:0]    s_red,
    input  logic [eims_pkg::CH_BITS-1:0]    s_green,
    input  logic [eims_pkg::CH_BITS-1:0]    s_blue,
    input  logic                            s_last_pixel,
    input  logic [eims_pkg::CH_BITS-1:0]    s_u_query,
    input  logic [eims_pkg::CH_BITS-1:0]    s_v_query,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [eims_pkg::COL_BITS-1:0]   m_column_index,
    output logic [eims_pkg::ROW_BITS-1:0]   m_row_index,
    output logic [eims_pkg::DENS_BITS-1:0]  m_density,
    output logic [eims_pkg::STAT_BITS-1:0]  m_status
);

    eims_pkg::cmd_t  cmd;
    eims_pkg::stat_t stat;

    eims_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_req_type (s_req_type),
        .s_ready    (s_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    eims_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_red          (s_red),
        .s_green        (s_green),
        .s_blue         (s_blue),
        .s_last_pixel   (s_last_pixel),
        .s_u_query      (s_u_query),
        .s_v_query      (s_v_query),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_column_index (m_column_index),
        .m_row_index    (m_row_index),
        .m_density      (m_density),
        .m_status       (m_status)
    );

`ifndef ASSERT_OFF
    a_no_accept_while_dividing: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.div_busy |-> !s_ready)
        else $error("input accepted while the divider is busy");

    a_one_item_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second input transfer right after an accepted one");

    a_status_result_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != eims_pkg::STATUS_OK)) |->
        (m_column_index == '0 && m_row_index == '0 && m_density == '0))
        else $error("non-sample result carries nonzero fields");
`endif

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int CELLS = eims_pkg::MAP_WIDTH * eims_pkg::MAP_HEIGHT;

    typedef struct {
        bit [eims_pkg::COL_BITS-1:0]  col;
        bit [eims_pkg::ROW_BITS-1:0]  row;
        bit [eims_pkg::DENS_BITS-1:0] dens;
        eims_pkg::status_t            stat;
    } sample_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    logic                            s_req_type;
    logic [eims_pkg::CH_BITS-1:0]    s_red;
    logic [eims_pkg::CH_BITS-1:0]    s_green;
    logic [eims_pkg::CH_BITS-1:0]    s_blue;
    logic                            s_last_pixel;
    logic [eims_pkg::CH_BITS-1:0]    s_u_query;
    logic [eims_pkg::CH_BITS-1:0]    s_v_query;
    logic                            m_valid;
    logic                            m_ready;
    logic [eims_pkg::COL_BITS-1:0]   m_column_index;
    logic [eims_pkg::ROW_BITS-1:0]   m_row_index;
    logic [eims_pkg::DENS_BITS-1:0]  m_density;
    logic [eims_pkg::STAT_BITS-1:0]  m_status;

    env_map_importance_sampler_core dut (.*);

    // Shadow copy of the sampler state.
    bit [23:0]        luma_mem [CELLS];
    bit [24:0]        row_cdf_m [eims_pkg::MAP_HEIGHT][eims_pkg::MAP_WIDTH+1];
    bit [31:0]        row_int_m [eims_pkg::MAP_HEIGHT];
    bit [24:0]        marg_cdf_m [eims_pkg::MAP_HEIGHT+1];
    bit [24:0]        probe_buf [eims_pkg::MAP_WIDTH+1];
    bit [39:0]        total_m;
    int unsigned      load_pos;
    bit               built_m;
    longint unsigned  sine_lut [eims_pkg::MAP_HEIGHT];

    sample_t          pending_samples[$];
    int               errors;
    bit               no_idle;
    int               hold_len;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #500ms;
        $display("status: fail");
        $finish;
    end

    function automatic longint unsigned sine_weight(int y);
        longint unsigned a;
        longint unsigned b;
        longint unsigned p;
        longint unsigned d;
        a = 2 * y + 1;
        b = 2 * eims_pkg::MAP_HEIGHT;
        p = a * (b - a);
        d = 5 * b * b - 4 * p;
        return (4096 * p + d / 2) / d;
    endfunction

    function automatic int first_at_least(int n, bit [24:0] key);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = n;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (probe_buf[mid] < key) lo = mid + 1;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic int clamp_pick(int idx, int lim);
        if (idx == 0) return 0;
        return (idx - 1 > lim - 1) ? lim - 1 : idx - 1;
    endfunction

    task automatic build_tables();
        longint unsigned sumint;
        longint unsigned rowsum;
        longint unsigned prefix;
        sumint = 0;
        for (int y = 0; y < eims_pkg::MAP_HEIGHT; y++) begin
            rowsum = 0;
            for (int x = 0; x < eims_pkg::MAP_WIDTH; x++)
                rowsum += luma_mem[y*eims_pkg::MAP_WIDTH + x];
            row_cdf_m[y][0] = '0;
            prefix = 0;
            for (int x = 0; x < eims_pkg::MAP_WIDTH; x++) begin
                prefix += luma_mem[y*eims_pkg::MAP_WIDTH + x];
                if (rowsum != 0) row_cdf_m[y][x+1] = 25'((prefix << 24) / rowsum);
                else row_cdf_m[y][x+1] = (x == eims_pkg::MAP_WIDTH - 1) ? eims_pkg::CDF_ONE
                                                                           : '0;
            end
            row_int_m[y] = 32'((rowsum * 256) / eims_pkg::MAP_WIDTH);
            sumint += row_int_m[y];
        end
        total_m = 40'(sumint / eims_pkg::MAP_HEIGHT);
        marg_cdf_m[0] = '0;
        prefix = 0;
        for (int y = 0; y < eims_pkg::MAP_HEIGHT; y++) begin
            prefix += row_int_m[y];
            if (sumint != 0) marg_cdf_m[y+1] = 25'((prefix << 24) / sumint);
            else marg_cdf_m[y+1] = (y == eims_pkg::MAP_HEIGHT - 1) ? eims_pkg::CDF_ONE : '0;
        end
    endtask

    task automatic predict_item(logic req, logic [15:0] r, logic [15:0] g, logic [15:0] b,
                                logic last, logic [15:0] u, logic [15:0] v);
        sample_t         res;
        longint unsigned luma;
        longint unsigned dens;
        int              vi;
        int              ui;
        int              du;
        int              dv;
        res.col  = '0;
        res.row  = '0;
        res.dens = '0;
        res.stat = eims_pkg::STATUS_EMPTY;
        if (req == eims_pkg::REQ_LOAD) begin
            built_m = 1'b0;
            if (load_pos < CELLS) begin
                luma = (13933 * longint'(r) + 46871 * longint'(g) + 4732 * longint'(b)
                        + 32768) >> 16;
                luma_mem[load_pos] = 24'(luma * sine_lut[load_pos / eims_pkg::MAP_WIDTH]);
                load_pos++;
            end
            if (!last) return;
            build_tables();
            load_pos = 0;
            built_m  = 1'b1;
            res.stat = (total_m != 0) ? eims_pkg::STATUS_BUILT : eims_pkg::STATUS_EMPTY;
        end else if (built_m && total_m != 0) begin
            for (int i = 0; i <= eims_pkg::MAP_HEIGHT; i++) probe_buf[i] = marg_cdf_m[i];
            vi = clamp_pick(first_at_least(eims_pkg::MAP_HEIGHT + 1, {1'b0, v, 8'h00}),
                            eims_pkg::MAP_HEIGHT);
            for (int i = 0; i <= eims_pkg::MAP_WIDTH; i++) probe_buf[i] = row_cdf_m[vi][i];
            ui = clamp_pick(first_at_least(eims_pkg::MAP_WIDTH + 1, {1'b0, u, 8'h00}),
                            eims_pkg::MAP_WIDTH);
            dv = (int'(v) * eims_pkg::MAP_HEIGHT) >> 16;
            du = (int'(u) * eims_pkg::MAP_WIDTH) >> 16;
            if (dv > eims_pkg::MAP_HEIGHT - 1) dv = eims_pkg::MAP_HEIGHT - 1;
            if (du > eims_pkg::MAP_WIDTH - 1) du = eims_pkg::MAP_WIDTH - 1;
            dens = 0;
            if (row_int_m[dv] != 0) begin
                dens = (longint'(luma_mem[dv*eims_pkg::MAP_WIDTH + du]) << 24) / total_m;
                if (dens > 64'hFFFF_FFFF) dens = 64'hFFFF_FFFF;
            end
            res.col  = eims_pkg::COL_BITS'(ui);
            res.row  = eims_pkg::ROW_BITS'(vi);
            res.dens = 32'(dens);
            res.stat = eims_pkg::STATUS_OK;
        end
        pending_samples.push_back(res);
    endtask

    task automatic send_item(logic req, logic [15:0] r, logic [15:0] g, logic [15:0] b,
                             logic last, logic [15:0] u, logic [15:0] v);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_red        <= r;
        s_green      <= g;
        s_blue       <= b;
        s_last_pixel <= last;
        s_u_query    <= u;
        s_v_query    <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_item(req, r, g, b, last, u, v);
    endtask

    task automatic load_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b, logic last);
        send_item(eims_pkg::REQ_LOAD, r, g, b, last, 16'($urandom), 16'($urandom));
    endtask

    task automatic query(logic [15:0] u, logic [15:0] v);
        send_item(eims_pkg::REQ_QUERY, 16'($urandom), 16'($urandom), 16'($urandom),
                  1'($urandom), u, v);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic test_query_unbuilt();
        query(16'h0000, 16'h0000);
        query(16'hFFFF, 16'hFFFF);
        query(16'h8000, 16'h7FFF);
        drain();
    endtask

    task automatic test_full_map();
        int          kind;
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        for (int y = 0; y < eims_pkg::MAP_HEIGHT; y++) begin
            kind = (y == 0) ? 1 : $urandom_range(0, 9);
            for (int x = 0; x < eims_pkg::MAP_WIDTH; x++) begin
                if (x % 64 == 0) no_idle = ($urandom_range(0, 3) != 0);
                case (kind)
                    0: begin
                        r = '0; g = '0; b = '0;
                    end
                    1: begin
                        r = ($urandom_range(0, 15) == 0) ? 16'hFFFF : 16'h0000;
                        g = ($urandom_range(0, 15) == 0) ? 16'hFFFF : 16'h0000;
                        b = ($urandom_range(0, 15) == 0) ? 16'hFFFF : 16'h0000;
                        if (x == 3) begin
                            r = 16'hFFFF; g = 16'hFFFF; b = 16'hFFFF;
                        end
                    end
                    2: begin
                        r = 16'($urandom_range(0, 255));
                        g = 16'($urandom_range(0, 255));
                        b = 16'($urandom_range(0, 255));
                    end
                    default: begin
                        r = 16'($urandom); g = 16'($urandom); b = 16'($urandom);
                    end
                endcase
                load_pixel(r, g, b, (y == eims_pkg::MAP_HEIGHT - 1)
                                    && (x == eims_pkg::MAP_WIDTH - 1));
            end
        end
        no_idle = 1'b0;
        drain();
    endtask

    task automatic test_directed_queries();
        query(16'h0000, 16'h0000);
        query(16'hFFFF, 16'hFFFF);
        query(16'h0000, 16'hFFFF);
        query(16'hFFFF, 16'h0000);
        query(16'h8000, 16'h8000);
        query(16'h0001, 16'hFFFE);
        drain();
    endtask

    task automatic test_random_queries(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
            query(16'($urandom), 16'($urandom));
        end
        no_idle = 1'b0;
        drain();
    endtask

    task automatic test_backpressure();
        hold_len = 400;
        no_idle  = 1'b1;
        for (int i = 0; i < 24; i++) query(16'($urandom), 16'($urandom));
        no_idle = 1'b0;
        drain();
    endtask

    task automatic test_load_clears_build();
        load_pixel(16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
        query(16'h1234, 16'h4321);
        query(16'($urandom), 16'($urandom));
        drain();
    endtask

    // The map is loaded past its end with a nearly dark image, so the total integral is
    // tiny and may round to zero, in which case the build reports an empty map.
    task automatic test_overflow_empty_map();
        int dim_at;
        dim_at = $urandom_range(0, CELLS - 1);
        no_idle = 1'b1;
        for (int i = 0; i < CELLS + 8; i++) begin
            if (i == dim_at) load_pixel(16'h0040, 16'h0000, 16'h0000, 1'b0);
            else load_pixel(16'h0000, 16'h0000, 16'h0000, i == CELLS + 7);
        end
        no_idle = 1'b0;
        drain();
        for (int i = 0; i < 12; i++) query(16'($urandom), 16'($urandom));
        drain();
    endtask

    initial begin : sink
        int gap;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_len > 0) begin
                m_ready <= 1'b0;
                repeat (hold_len) @(posedge aclk);
                hold_len = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        sample_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_samples.size() == 0) begin
                $error("Unexpected result transfer.");
                errors++;
            end else begin
                want = pending_samples.pop_front();
                if (m_column_index !== want.col) begin
                    $error("column_index: expected %0d, got %0d", want.col, m_column_index);
                    errors++;
                end
                if (m_row_index !== want.row) begin
                    $error("row_index: expected %0d, got %0d", want.row, m_row_index);
                    errors++;
                end
                if (m_density !== want.dens) begin
                    $error("density: expected %0h, got %0h", want.dens, m_density);
                    errors++;
                end
                if (m_status !== want.stat) begin
                    $error("status: expected %0d, got %0d", want.stat, m_status);
                    errors++;
                end
            end
        end
    end

    initial begin
        errors   = 0;
        no_idle  = 1'b0;
        hold_len = 0;
        load_pos = 0;
        built_m  = 1'b0;
        total_m  = '0;
        for (int y = 0; y < eims_pkg::MAP_HEIGHT; y++) sine_lut[y] = sine_weight(y);
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_req_type   <= eims_pkg::REQ_LOAD;
        s_red        <= '0;
        s_green      <= '0;
        s_blue       <= '0;
        s_last_pixel <= 1'b0;
        s_u_query    <= '0;
        s_v_query    <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_query_unbuilt();
        test_full_map();
        test_directed_queries();
        test_random_queries(880);
        test_backpressure();
        test_load_clears_build();
        test_overflow_empty_map();

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/eims_pkg.sv
rtl/eims_div.sv
rtl/eims_dp.sv
rtl/eims_ctrl.sv
rtl/env_map_importance_sampler_core.sv
dv/tb_top.sv
